// File: hdl/range_union_find_online_defines.svh
// ----------------------------------------------------------------------------
// Range union-find engine: assertion macros
// Shared property wrappers, clocked on clk_i and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef RANGE_UNION_FIND_ONLINE_DEFINES_SVH
`define RANGE_UNION_FIND_ONLINE_DEFINES_SVH

// Condition must hold at every edge out of reset.
`define RUFO_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define RUFO_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define RUFO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/rufo_pkg.sv
// ----------------------------------------------------------------------------
// Range union-find engine: package
// Sizes, stack entry, controller commands/status and state encoding.
// ----------------------------------------------------------------------------
package rufo_pkg;

  localparam int unsigned NODES     = 1024;
  localparam int unsigned LEVELS    = 10;
  localparam int unsigned NODE_W    = 10;
  localparam int unsigned SIZE_W    = 11;
  localparam int unsigned LVL_W     = 4;
  localparam int unsigned WORD_W    = SIZE_W + NODE_W;
  localparam int unsigned MEM_DEPTH = (LEVELS + 1) * NODES;
  localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);
  localparam int unsigned STK_DEPTH = 2 * LEVELS + 2;
  localparam int unsigned SP_W      = $clog2(STK_DEPTH + 1);
  localparam int unsigned STK_IDX_W = $clog2(STK_DEPTH);

  // one pending union: level 0 is the main structure
  typedef struct packed {
    logic [LVL_W-1:0]  lvl;
    logic [NODE_W-1:0] u;
    logic [NODE_W-1:0] v;
  } join_t;

  typedef struct packed {
    logic clear;   // write one reset entry
    logic load;    // capture request
    logic start;   // push the covering joins
    logic pop;     // take top join, walk from u
    logic query;   // walk from node_a at level 0
    logic step;    // follow parent pointer
    logic take_u;  // latch root of u, walk from v
    logic take_v;  // latch root of v
    logic link1;   // hang loser under winner
    logic link2;   // winner size, cascade or count
    logic emit;    // load result register
  } rufo_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic stk_empty;
    logic is_root;
    logic same_root;
    logic out_busy;
  } rufo_sts_t;

  typedef enum logic [10:0] {
    ST_CLEAR  = 11'b000_0000_0001,
    ST_IDLE   = 11'b000_0000_0010,
    ST_START  = 11'b000_0000_0100,
    ST_POP    = 11'b000_0000_1000,
    ST_UREAD  = 11'b000_0001_0000,
    ST_UCHECK = 11'b000_0010_0000,
    ST_VREAD  = 11'b000_0100_0000,
    ST_VCHECK = 11'b000_1000_0000,
    ST_LINK   = 11'b001_0000_0000,
    ST_QCHECK = 11'b010_0000_0000,
    ST_RESULT = 11'b100_0000_0000
  } rufo_state_e;

endpackage

// File: hdl/rufo_dpath.sv
// ----------------------------------------------------------------------------
// Range union-find engine: datapath
// Parent/size memory for all levels, join stack, walker and result register.
// ----------------------------------------------------------------------------
module rufo_dpath import rufo_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rufo_cmd_t         cmd_i,
  output rufo_sts_t         sts_o,
  input  logic [NODE_W-1:0] node_a_i,
  input  logic [NODE_W-1:0] node_b_i,
  input  logic [SIZE_W-1:0] span_len_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [NODE_W-1:0] root_a_o,
  output logic [SIZE_W-1:0] size_a_o,
  output logic [SIZE_W-1:0] components_o,
  output logic              range_error_o
);

  // word = {size, parent}; address = {level, node}
  logic [WORD_W-1:0] mem [MEM_DEPTH];
  logic [WORD_W-1:0] rdata_q;

  logic [NODE_W-1:0] a_q, b_q;
  logic [SIZE_W-1:0] len_q;
  logic              err_q;
  join_t             cur_q;
  logic [NODE_W-1:0] x_q, rx_q, ry_q;
  logic [SIZE_W-1:0] sx_q, sy_q;
  join_t             stk_q [STK_DEPTH];
  logic [SP_W-1:0]   sp_q;
  logic [SIZE_W-1:0] comp_q;
  logic [ADDR_W-1:0] clr_q;
  logic              out_valid_q;

  logic [NODE_W-1:0] rd_par;
  logic [SIZE_W-1:0] rd_size;
  assign rd_par  = rdata_q[NODE_W-1:0];
  assign rd_size = rdata_q[WORD_W-1:NODE_W];

  // request range check
  logic [NODE_W+1:0] end_a, end_b;
  logic              req_err;
  assign end_a   = {2'b00, node_a_i} + {1'b0, span_len_i};
  assign end_b   = {2'b00, node_b_i} + {1'b0, span_len_i};
  assign req_err = (span_len_i != '0) &&
                   ((end_a > (NODE_W+2)'(NODES)) || (end_b > (NODE_W+2)'(NODES)));

  // top level of the cover: floor(log2(len)), capped
  logic [LVL_W-1:0]  k;
  logic [SIZE_W-1:0] blk, tail;
  logic              two_blk;
  always_comb begin
    k = '0;
    for (int i = 1; i < SIZE_W; i++) begin
      if (len_q[i] && (i <= LEVELS)) k = LVL_W'(i);
    end
  end
  assign blk     = SIZE_W'(1) << k;
  assign two_blk = blk < len_q;
  assign tail    = len_q - blk;

  // link decision: first operand wins ties
  logic              win_u;
  logic [NODE_W-1:0] winner, loser, half;
  logic [SIZE_W-1:0] lose_size;
  logic [LVL_W-1:0]  child_lvl;
  assign win_u     = sx_q >= sy_q;
  assign winner    = win_u ? rx_q : ry_q;
  assign loser     = win_u ? ry_q : rx_q;
  assign lose_size = win_u ? sy_q : sx_q;
  assign child_lvl = cur_q.lvl - LVL_W'(1);
  assign half      = NODE_W'(1) << child_lvl;

  // memory port
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [WORD_W-1:0] wdata;
  always_comb begin
    we    = 1'b0;
    waddr = clr_q;
    wdata = {SIZE_W'(1), clr_q[NODE_W-1:0]};
    priority if (cmd_i.clear) begin
      we = 1'b1;
    end else if (cmd_i.link1) begin
      we    = 1'b1;
      waddr = ADDR_W'({cur_q.lvl, loser});
      wdata = {lose_size, winner};
    end else if (cmd_i.link2) begin
      we    = 1'b1;
      waddr = ADDR_W'({cur_q.lvl, winner});
      wdata = {sx_q + sy_q, winner};
    end
  end
  assign raddr = ADDR_W'({cur_q.lvl, x_q});

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      comp_q      <= SIZE_W'(NODES);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + ADDR_W'(1);
      if (cmd_i.start && !err_q && (len_q != '0)) begin
        sp_q <= two_blk ? SP_W'(2) : SP_W'(1);
      end else if (cmd_i.pop) begin
        sp_q <= sp_q - SP_W'(1);
      end else if (cmd_i.link2 && (cur_q.lvl != '0)) begin
        sp_q <= sp_q + SP_W'(2);
      end
      if (cmd_i.link2 && (cur_q.lvl == '0)) comp_q <= comp_q - SIZE_W'(1);
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q   <= node_a_i;
      b_q   <= node_b_i;
      len_q <= span_len_i;
      err_q <= req_err;
    end
    if (cmd_i.start && !err_q && (len_q != '0)) begin
      if (two_blk) begin
        stk_q[0] <= '{lvl: k, u: a_q + tail[NODE_W-1:0], v: b_q + tail[NODE_W-1:0]};
        stk_q[1] <= '{lvl: k, u: a_q, v: b_q};
      end else begin
        stk_q[0] <= '{lvl: k, u: a_q, v: b_q};
      end
    end
    if (cmd_i.pop) begin
      cur_q <= stk_q[STK_IDX_W'(sp_q - SP_W'(1))];
      x_q   <= stk_q[STK_IDX_W'(sp_q - SP_W'(1))].u;
    end
    if (cmd_i.query) begin
      cur_q.lvl <= '0;
      x_q       <= a_q;
    end
    if (cmd_i.step) x_q <= rd_par;
    if (cmd_i.take_u) begin
      rx_q <= x_q;
      sx_q <= rd_size;
      x_q  <= cur_q.v;
    end
    if (cmd_i.take_v) begin
      ry_q <= x_q;
      sy_q <= rd_size;
    end
    if (cmd_i.link2 && (cur_q.lvl != '0)) begin
      if (sp_q < SP_W'(STK_DEPTH)) begin
        stk_q[STK_IDX_W'(sp_q)] <= '{lvl: child_lvl, u: cur_q.u + half,
                                     v: cur_q.v + half};
      end
      if (sp_q < SP_W'(STK_DEPTH - 1)) begin
        stk_q[STK_IDX_W'(sp_q + SP_W'(1))] <= '{lvl: child_lvl, u: cur_q.u, v: cur_q.v};
      end
    end
    if (cmd_i.emit) begin
      root_a_o      <= x_q;
      size_a_o      <= rd_size;
      components_o  <= comp_q;
      range_error_o <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.clr_done  = clr_q == ADDR_W'(MEM_DEPTH - 1);
  assign sts_o.stk_empty = sp_q == '0;
  assign sts_o.is_root   = rd_par == x_q;
  assign sts_o.same_root = rx_q == ry_q;
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

endmodule

// File: hdl/rufo_ctrl.sv
// ----------------------------------------------------------------------------
// Range union-find engine: controller
// Sequences clearing, cascade of joins, root walks and result hand-off.
// ----------------------------------------------------------------------------
module rufo_ctrl import rufo_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  rufo_sts_t sts_i,
  output rufo_cmd_t cmd_o
);

  rufo_state_e state_q, state_d;

  // phase flags for the shared final state
  logic link_ph_q, walk_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLEAR;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_START;
        end
      end
      ST_START: begin
        cmd_o.start = 1'b1;
        state_d     = ST_POP;
      end
      ST_POP: begin
        if (sts_i.stk_empty) begin
          cmd_o.query = 1'b1;
          state_d     = ST_QCHECK;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = ST_UREAD;
        end
      end
      ST_UREAD: state_d = ST_UCHECK;
      ST_UCHECK: begin
        if (sts_i.is_root) begin
          cmd_o.take_u = 1'b1;
          state_d      = ST_VREAD;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = ST_UREAD;
        end
      end
      ST_VREAD: state_d = ST_VCHECK;
      ST_VCHECK: begin
        if (sts_i.is_root) begin
          cmd_o.take_v = 1'b1;
          state_d      = ST_LINK;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = ST_VREAD;
        end
      end
      ST_LINK: begin
        // hangs the loser here, ST_RESULT then updates the winner; equal roots skip both
        if (sts_i.same_root) begin
          state_d = ST_POP;
        end else begin
          cmd_o.link1 = 1'b1;
          state_d     = ST_RESULT;
        end
      end
      ST_QCHECK: begin
        // the read address settles here; rdata_q is valid in ST_RESULT
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        state_d = ST_RESULT;
      end
      default: state_d = ST_CLEAR;
    endcase
    // ST_RESULT is shared: after link1 it finishes the link, after a query
    // walk it steps, emits, or waits on out_busy; tracked by the flags below.
    if (state_q == ST_RESULT) begin
      if (link_ph_q) begin
        cmd_o.link2 = 1'b1;
        state_d     = ST_POP;
      end else if (!walk_rd_q) begin
        state_d = ST_RESULT;
      end else if (!sts_i.is_root) begin
        cmd_o.step = 1'b1;
        state_d    = ST_QCHECK;
      end else if (!sts_i.out_busy) begin
        cmd_o.emit = 1'b1;
        state_d    = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_ph_q <= 1'b0;
      walk_rd_q <= 1'b0;
    end else begin
      link_ph_q <= cmd_o.link1;
      // rdata is valid from the cycle after the query address settles
      walk_rd_q <= (state_q == ST_QCHECK) || ((state_q == ST_RESULT) && walk_rd_q &&
                   sts_i.is_root);
    end
  end

  assign in_stall_o = state_q != ST_IDLE;

endmodule

// File: hdl/range_union_find_online.sv
// ----------------------------------------------------------------------------
// Range union-find engine: top level
// Joins node_a+i with node_b+i for i below span_len; reports node_a's root.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i / in_stall_o) carries node_a, node_b and
//   span_len; one request is taken when valid is high and stall is low.
//   Result channel (out_valid_o / out_stall_i) returns one result per
//   request: root of node_a, its component size, the component count and
//   a range error flag (span past the last node, nothing changed).
//   After reset the block clears all 11264 entries of its parent/size
//   memory, one entry per cycle (main structure plus ten helper levels),
//   with in_stall_o high; the join stack and component count reset at once.
//   Each union walks from u and then from v to their roots, one parent
//   step at a time, and links the two roots unless they already match;
//   a final walk from node_a at level 0 finds the root that is reported.
//   A linking helper-level union cascades into two unions one level down,
//   so time depends on the data. All walks share the single memory read
//   port, which sets the rate. A finished result waits in the output
//   register while the receiver stalls; the next request is already taken
//   and worked on, and held only at its own hand-off.
// ----------------------------------------------------------------------------
`include "range_union_find_online_defines.svh"

module range_union_find_online import rufo_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [NODE_W-1:0] node_a_i,
  input  logic [NODE_W-1:0] node_b_i,
  input  logic [SIZE_W-1:0] span_len_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [NODE_W-1:0] root_a_o,
  output logic [SIZE_W-1:0] size_a_o,
  output logic [SIZE_W-1:0] components_o,
  output logic              range_error_o
);

  rufo_cmd_t cmd;
  rufo_sts_t sts;

  // controller: sequencing only
  rufo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: memory, stack, walker, result register
  rufo_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .node_a_i      (node_a_i),
    .node_b_i      (node_b_i),
    .span_len_i    (span_len_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .root_a_o      (root_a_o),
    .size_a_o      (size_a_o),
    .components_o  (components_o),
    .range_error_o (range_error_o)
  );

  // an idle block holds no pending unions
  `RUFO_ASSERT_IMPL(a_idle_stack_empty, !in_stall_o, sts.stk_empty, "pending joins while idle")
  // a taken request makes the block busy
  `RUFO_ASSERT_NEXT(a_accept_busy, in_valid_i && !in_stall_o, in_stall_o, "not busy after request")
  // only distinct roots get linked
  `RUFO_ASSERT_IMPL(a_link_distinct, cmd.link1, !sts.same_root, "link of equal roots")
  // at least one component always remains
  `RUFO_ASSERT_IMPL(a_comp_nonzero, out_valid_o, components_o != '0, "zero components")

endmodule
